// ===== rtl/lpbc_pkg.sv =====
// lpbc_pkg: payload types, register codes and fixed-point helpers for the layer
// pixel blend compositor. No dependencies.

package lpbc_pkg;

  localparam int unsigned ChBits = 16;
  localparam logic [ChBits-1:0] ChOne = '1;

  typedef enum logic [1:0] {
    BLEND_NORMAL   = 2'd0,
    BLEND_MULTIPLY = 2'd1,
    BLEND_SCREEN   = 2'd2,
    BLEND_OVERLAY  = 2'd3
  } blend_mode_e;

  typedef enum logic [0:0] {
    REG_BLEND_MODE    = 1'b0,
    REG_LAYER_OPACITY = 1'b1
  } reg_idx_e;

  localparam logic [15:0] OpacityReset = 16'hffff;

  typedef struct packed {
    logic [15:0] dst_red;
    logic [15:0] dst_green;
    logic [15:0] dst_blue;
    logic [15:0] dst_alpha;
    logic [15:0] src_red;
    logic [15:0] src_green;
    logic [15:0] src_blue;
    logic [15:0] src_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
  } pix_out_t;

  // floor(p / 65535) for p up to 65535*65535, as an add and a shift
  function automatic logic [ChBits-1:0] div_one(input logic [2*ChBits-1:0] p);
    logic [2*ChBits:0] t;
    t = {1'b0, p} + {{(ChBits+1){1'b0}}, p[2*ChBits-1:ChBits]} + 1'b1;
    return t[2*ChBits-1:ChBits];
  endfunction

endpackage

// ===== rtl/layer_pixel_blend_composite_top.sv =====
// layer_pixel_blend_composite_top: blend mode plus source-over compositor, pipelined.
// Depends on lpbc_pkg for payload structs, register codes and div_one.
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+---------------------------
//  in      | in  | in_valid_i / in_ready_o  | in_data_i  (pix_in_t)
//  out     | out | out_valid_o / out_ready_i| out_data_o (pix_out_t)
//  config  | in  | psel/penable/pwrite      | paddr, pwdata, prdata
//
// one pixel pair per cycle while the output does not stall; a result passes through
// 23 register stages on its way to the output register: 6 arithmetic stages, 16 one-bit stages of
// the restoring divider for the division by the output alpha, one output register.
// reset clears all valid bits and sets blend_mode to normal and layer_opacity to
// full. an output stall freezes the whole pipe; a one-entry skid buffer still takes
// one transfer.

module layer_pixel_blend_composite_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lpbc_pkg::pix_in_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lpbc_pkg::pix_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned W = lpbc_pkg::ChBits;
  localparam int unsigned DivSteps = W;

  // ---------------- configuration ----------------
  lpbc_pkg::blend_mode_e mode_q;
  logic [W-1:0]          opacity_q;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= lpbc_pkg::BLEND_NORMAL;
      opacity_q <= lpbc_pkg::OpacityReset;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      unique case (lpbc_pkg::reg_idx_e'(paddr[2]))
        lpbc_pkg::REG_BLEND_MODE:    mode_q <= lpbc_pkg::blend_mode_e'(pwdata[1:0]);
        lpbc_pkg::REG_LAYER_OPACITY: opacity_q <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (lpbc_pkg::reg_idx_e'(paddr[2]))
      lpbc_pkg::REG_BLEND_MODE:    prdata = {30'd0, mode_q};
      lpbc_pkg::REG_LAYER_OPACITY: prdata = {16'd0, opacity_q};
      default: ;
    endcase
  end

  // ---------------- flow control ----------------
  logic              en;
  logic              skid_v_q;
  lpbc_pkg::pix_in_t skid_q;
  logic              feed_v;
  lpbc_pkg::pix_in_t feed;
  logic              out_v_q;

  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = !skid_v_q;
  assign feed_v     = skid_v_q || (in_valid_i && in_ready_o);
  assign feed       = skid_v_q ? skid_q : in_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (en) begin
      skid_v_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_valid_i && in_ready_o) begin
      skid_q <= in_data_i;
    end
  end

  // ---------------- stage 1: products ----------------
  logic [W-1:0] fd [3];
  logic [W-1:0] fs [3];
  logic [W-1:0] ma [3];
  logic [W-1:0] mb [3];
  logic         inv [3];

  assign fd[0] = feed.dst_red;
  assign fd[1] = feed.dst_green;
  assign fd[2] = feed.dst_blue;
  assign fs[0] = feed.src_red;
  assign fs[1] = feed.src_green;
  assign fs[2] = feed.src_blue;

  logic              v1_q;
  lpbc_pkg::pix_in_t px1_q;
  logic [2*W-1:0]    p1_q [3];
  logic              hi1_q [3];
  logic [2*W-1:0]    sap1_q;

  for (genvar c = 0; c < 3; c++) begin : g_s1
    // screen and the upper half of overlay work on the complements
    assign inv[c] = (mode_q == lpbc_pkg::BLEND_SCREEN) ||
                    (mode_q == lpbc_pkg::BLEND_OVERLAY && fd[c][W-1]);
    assign ma[c]  = inv[c] ? ~fd[c] : fd[c];
    assign mb[c]  = inv[c] ? ~fs[c] : fs[c];
    always_ff @(posedge clk_i) begin
      if (en) begin
        p1_q[c]  <= ma[c] * mb[c];
        hi1_q[c] <= fd[c][W-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px1_q  <= feed;
      sap1_q <= feed.src_alpha * opacity_q;
    end
  end

  // ---------------- stage 2: blend result, effective source alpha ----------------
  logic [W-1:0]   q2 [3];
  logic [2*W-1:0] r2 [3];
  logic [W-1:0]   t2 [3];
  logic [W-1:0]   res2 [3];
  logic [W-1:0]   s1v [3];

  assign s1v[0] = px1_q.src_red;
  assign s1v[1] = px1_q.src_green;
  assign s1v[2] = px1_q.src_blue;

  logic              v2_q;
  lpbc_pkg::pix_in_t px2_q;
  logic [W-1:0]      res2_q [3];
  logic [W-1:0]      sa2_q;

  for (genvar c = 0; c < 3; c++) begin : g_s2
    always_comb begin
      q2[c] = lpbc_pkg::div_one(p1_q[c]);
      // remainder of the division by one, for the doubled overlay product
      r2[c] = p1_q[c] - {q2[c], {W{1'b0}}} + {{W{1'b0}}, q2[c]};
      t2[c] = {q2[c][W-2:0], 1'b0} + {{(W-1){1'b0}}, r2[c][W-1]};
      unique case (mode_q)
        lpbc_pkg::BLEND_NORMAL:   res2[c] = s1v[c];
        lpbc_pkg::BLEND_MULTIPLY: res2[c] = q2[c];
        lpbc_pkg::BLEND_SCREEN:   res2[c] = ~q2[c];
        lpbc_pkg::BLEND_OVERLAY:  res2[c] = hi1_q[c] ? ~t2[c] : t2[c];
        default:                  res2[c] = s1v[c];
      endcase
    end
    always_ff @(posedge clk_i) begin
      if (en) res2_q[c] <= res2[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px2_q <= px1_q;
      sa2_q <= lpbc_pkg::div_one(sap1_q);
    end
  end

  // ---------------- stage 3: destination weight product ----------------
  logic              v3_q;
  lpbc_pkg::pix_in_t px3_q;
  logic [W-1:0]      res3_q [3];
  logic [W-1:0]      sa3_q;
  logic [2*W-1:0]    dwp3_q;
  logic [W-1:0]      nsa2;

  // one minus sa, kept at channel width before the product
  assign nsa2 = ~sa2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px3_q  <= px2_q;
      res3_q <= res2_q;
      sa3_q  <= sa2_q;
      dwp3_q <= px2_q.dst_alpha * nsa2;
    end
  end

  // ---------------- stage 4: dw and output alpha ----------------
  logic [W-1:0] dw4;
  logic [W:0]   fa4;

  assign dw4 = lpbc_pkg::div_one(dwp3_q);
  assign fa4 = {1'b0, sa3_q} + {1'b0, dw4};

  logic              v4_q;
  lpbc_pkg::pix_in_t px4_q;
  logic [W-1:0]      res4_q [3];
  logic [W-1:0]      sa4_q;
  logic [W-1:0]      dw4_q;
  logic [W-1:0]      fa4_q;
  logic              zero4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px4_q   <= px3_q;
      res4_q  <= res3_q;
      sa4_q   <= sa3_q;
      dw4_q   <= dw4;
      fa4_q   <= fa4[W] ? lpbc_pkg::ChOne : fa4[W-1:0];
      zero4_q <= (sa3_q == '0);
    end
  end

  // ---------------- stage 5: weighted products ----------------
  logic [W-1:0] d4v [3];

  assign d4v[0] = px4_q.dst_red;
  assign d4v[1] = px4_q.dst_green;
  assign d4v[2] = px4_q.dst_blue;

  logic              v5_q;
  lpbc_pkg::pix_in_t px5_q;
  logic [2*W-1:0]    ps5_q [3];
  logic [2*W-1:0]    pd5_q [3];
  logic [W-1:0]      fa5_q;
  logic              zero5_q;

  for (genvar c = 0; c < 3; c++) begin : g_s5
    always_ff @(posedge clk_i) begin
      if (en) begin
        ps5_q[c] <= res4_q[c] * sa4_q;
        pd5_q[c] <= d4v[c] * dw4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px5_q   <= px4_q;
      fa5_q   <= fa4_q;
      zero5_q <= zero4_q;
    end
  end

  // ---------------- stage 6: numerator ----------------
  // the sum is at most 65535*fa, so the quotient fits the channel width
  logic              v6_q;
  lpbc_pkg::pix_in_t px6_q;
  logic [2*W-1:0]    num6_q [3];
  logic [W-1:0]      fa6_q;
  logic              zero6_q;

  for (genvar c = 0; c < 3; c++) begin : g_s6
    always_ff @(posedge clk_i) begin
      if (en) num6_q[c] <= ps5_q[c] + pd5_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px6_q   <= px5_q;
      fa6_q   <= fa5_q;
      zero6_q <= zero5_q;
    end
  end

  // ---------------- divider stages: one quotient bit each ----------------
  // upper half holds the partial remainder, lower half the dividend bits
  // still to come and the quotient bits shifted in behind them
  logic              dv_q   [DivSteps];
  lpbc_pkg::pix_in_t dpx_q  [DivSteps];
  logic [2*W-1:0]    dr_q   [DivSteps][3];
  logic [W-1:0]      dfa_q  [DivSteps];
  logic              dzero_q[DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    logic [2*W-1:0]    src_r [3];
    logic [2*W-1:0]    nxt_r [3];
    logic [W-1:0]      src_fa;
    lpbc_pkg::pix_in_t src_px;
    logic              src_zero;

    if (k == 0) begin : g_first
      assign src_fa   = fa6_q;
      assign src_px   = px6_q;
      assign src_zero = zero6_q;
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign src_r[c] = num6_q[c];
      end
    end else begin : g_next
      assign src_fa   = dfa_q[k-1];
      assign src_px   = dpx_q[k-1];
      assign src_zero = dzero_q[k-1];
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign src_r[c] = dr_q[k-1][c];
      end
    end

    for (genvar c = 0; c < 3; c++) begin : g_step
      logic [W:0] t;
      logic [W:0] diff;
      logic       ge;
      always_comb begin
        t       = {src_r[c][2*W-1:W], src_r[c][W-1]};
        diff    = t - {1'b0, src_fa};
        ge      = (t >= {1'b0, src_fa});
        nxt_r[c] = ge ? {diff[W-1:0], src_r[c][W-2:0], 1'b1}
                      : {t[W-1:0], src_r[c][W-2:0], 1'b0};
      end
      always_ff @(posedge clk_i) begin
        if (en) dr_q[k][c] <= nxt_r[c];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dpx_q[k]   <= src_px;
        dfa_q[k]   <= src_fa;
        dzero_q[k] <= src_zero;
      end
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      for (int k = 0; k < DivSteps; k++) dv_q[k] <= 1'b0;
    end else if (en) begin
      v1_q <= feed_v;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      dv_q[0] <= v6_q;
      for (int k = 1; k < DivSteps; k++) dv_q[k] <= dv_q[k-1];
    end
  end

  // ---------------- output register ----------------
  lpbc_pkg::pix_out_t out_d;
  lpbc_pkg::pix_out_t out_q;
  logic               out_zero_q;
  lpbc_pkg::pix_in_t  lpx;

  assign lpx = dpx_q[DivSteps-1];

  always_comb begin
    if (dzero_q[DivSteps-1]) begin
      // transparent source: destination passes through
      out_d.out_red   = lpx.dst_red;
      out_d.out_green = lpx.dst_green;
      out_d.out_blue  = lpx.dst_blue;
      out_d.out_alpha = lpx.dst_alpha;
    end else begin
      out_d.out_red   = dr_q[DivSteps-1][0][W-1:0];
      out_d.out_green = dr_q[DivSteps-1][1][W-1:0];
      out_d.out_blue  = dr_q[DivSteps-1][2][W-1:0];
      out_d.out_alpha = dfa_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_q[DivSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q      <= out_d;
      out_zero_q <= dzero_q[DivSteps-1];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // a transfer held in the skid buffer stays there until the pipe moves
  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !en |=> skid_v_q)
    else $error("skid entry lost during stall");

  // a composited pixel never carries zero alpha
  a_alpha_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_zero_q |-> out_q.out_alpha != '0)
    else $error("zero alpha on composited pixel");

  // an item entering the pipe shows up in the first stage
  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && feed_v |=> v1_q)
    else $error("item dropped at pipe entry");
`endif

endmodule
